// ===== design/kmd_pkg.sv =====
package kmd_pkg;

    // fixed field widths
    localparam int ROW_IDX_W  = 4;
    localparam int COL_BITS_W = 10;
    localparam int RELOAD_W   = 8;
    localparam int COUNT_W    = 7;

    // default matrix size
    localparam int ROWS_DEF = 10;
    localparam int COLS_DEF = 10;

    // reset and saturation values
    localparam logic [RELOAD_W-1:0] RELOAD_AT_RESET = 8'd5;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = 7'd127;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic update;
        logic sweep_step;
        logic load_out;
    } kmd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fire;
        logic sweep_last;
        logic out_free;
    } kmd_status_t;

endpackage

// ===== design/kmd_ctrl.sv =====
module kmd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kmd_pkg::kmd_status_t status,
    output kmd_pkg::kmd_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_FORM  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.update = 1'b1;
                state_next = status.fire ? ST_SWEEP : ST_FORM;
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_FORM;
                end
            end
            ST_FORM: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/kmd_datapath.sv =====
module kmd_datapath #(
    parameter int ROWS = kmd_pkg::ROWS_DEF,
    parameter int COLS = kmd_pkg::COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [kmd_pkg::ROW_IDX_W-1:0]   s_row_index,
    input  logic [kmd_pkg::COL_BITS_W-1:0]  s_column_bits,
    input  logic                            s_end_of_pass,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kmd_pkg::COL_BITS_W-1:0]  m_stable_row,
    output logic                            m_settled,
    output logic [kmd_pkg::COUNT_W-1:0]     m_pressed_count,
    input  logic                            cfg_valid,
    input  logic [kmd_pkg::RELOAD_W-1:0]    cfg_data,
    input  kmd_pkg::kmd_cmd_t               cmd,
    output kmd_pkg::kmd_status_t            status
);

    localparam int SW      = (COLS < kmd_pkg::COL_BITS_W) ? COLS : kmd_pkg::COL_BITS_W;
    localparam int ADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PC_W    = $clog2(SW + 1);
    localparam int TOTAL_W = $clog2(ROWS * SW + 1);

    // row stores
    logic [SW-1:0] pending_reg [ROWS];
    logic [SW-1:0] stable_reg  [ROWS];

    // latched item
    logic [kmd_pkg::ROW_IDX_W-1:0]  row_idx_reg;
    logic [kmd_pkg::COL_BITS_W-1:0] col_reg;
    logic                           last_reg;

    logic [kmd_pkg::RELOAD_W-1:0] reload_reg, reload_next;
    logic [kmd_pkg::RELOAD_W-1:0] quiet_reg, quiet_next;
    logic [kmd_pkg::COUNT_W-1:0]  key_total_reg, key_total_next;
    logic [TOTAL_W-1:0]           acc_reg, acc_next;
    logic [ADDR_W-1:0]            sweep_idx_reg, sweep_idx_next;
    logic                         m_valid_reg, m_valid_next;

    logic [kmd_pkg::COL_BITS_W-1:0] stable_row_reg;
    logic                           settled_reg;
    logic [kmd_pkg::COUNT_W-1:0]    pressed_reg;

    logic                         row_valid;
    logic [ADDR_W-1:0]            row_addr;
    logic [ADDR_W-1:0]            pend_addr;
    logic [SW-1:0]                pend_rd;
    logic [SW-1:0]                col_trunc;
    logic                         changed;
    logic [kmd_pkg::RELOAD_W-1:0] reload_eff;
    logic [kmd_pkg::RELOAD_W-1:0] after_load;
    logic                         dec;
    logic [PC_W-1:0]              pc;
    logic [TOTAL_W-1:0]           acc_sum;
    logic [kmd_pkg::COUNT_W-1:0]  total_sat;

    // row decode and pending compare
    always_comb begin
        row_valid  = 32'(row_idx_reg) < 32'(ROWS);
        row_addr   = row_valid ? ADDR_W'(row_idx_reg) : '0;
        pend_addr  = cmd.sweep_step ? sweep_idx_reg : row_addr;
        pend_rd    = pending_reg[pend_addr];
        col_trunc  = SW'(col_reg);
        changed    = row_valid && (pend_rd != col_trunc);
        reload_eff = (reload_reg == '0) ? kmd_pkg::RELOAD_W'(1) : reload_reg;
        after_load = changed ? reload_eff : quiet_reg;
        dec        = last_reg && (after_load != '0);
    end

    // popcount of the swept row and running total
    always_comb begin
        pc = '0;
        for (int i = 0; i < SW; i++) begin
            pc = pc + PC_W'(pend_rd[i]);
        end
        acc_sum = acc_reg + TOTAL_W'(pc);
        if (32'(acc_sum) > 32'(kmd_pkg::COUNT_MAX)) begin
            total_sat = kmd_pkg::COUNT_MAX;
        end else begin
            total_sat = kmd_pkg::COUNT_W'(acc_sum);
        end
    end

    // status to controller
    always_comb begin
        status.fire       = dec && (after_load == kmd_pkg::RELOAD_W'(1));
        status.sweep_last = sweep_idx_reg == ADDR_W'(ROWS - 1);
        status.out_free   = !m_valid_reg || m_ready;
    end

    // next values of control registers
    always_comb begin
        reload_next    = cfg_valid ? cfg_data : reload_reg;
        quiet_next     = quiet_reg;
        acc_next       = acc_reg;
        sweep_idx_next = sweep_idx_reg;
        key_total_next = key_total_reg;
        if (cmd.update) begin
            quiet_next     = dec ? after_load - kmd_pkg::RELOAD_W'(1) : after_load;
            acc_next       = '0;
            sweep_idx_next = '0;
        end
        if (cmd.sweep_step) begin
            acc_next       = acc_sum;
            sweep_idx_next = sweep_idx_reg + ADDR_W'(1);
            if (status.sweep_last) begin
                key_total_next = total_sat;
            end
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // state registers and row stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                pending_reg[r] <= '0;
                stable_reg[r]  <= '0;
            end
            reload_reg    <= kmd_pkg::RELOAD_AT_RESET;
            quiet_reg     <= kmd_pkg::RELOAD_AT_RESET;
            key_total_reg <= '0;
            acc_reg       <= '0;
            sweep_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            reload_reg    <= reload_next;
            quiet_reg     <= quiet_next;
            key_total_reg <= key_total_next;
            acc_reg       <= acc_next;
            sweep_idx_reg <= sweep_idx_next;
            m_valid_reg   <= m_valid_next;
            if (cmd.update && changed) begin
                pending_reg[row_addr] <= col_trunc;
            end
            if (cmd.sweep_step) begin
                stable_reg[sweep_idx_reg] <= pend_rd;
            end
        end
    end

    // item capture and result register
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            row_idx_reg <= s_row_index;
            col_reg     <= s_column_bits;
            last_reg    <= s_end_of_pass;
        end
        if (cmd.load_out) begin
            stable_row_reg <= row_valid ? kmd_pkg::COL_BITS_W'(stable_reg[row_addr]) : '0;
            settled_reg    <= quiet_reg == '0;
            pressed_reg    <= key_total_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_stable_row    = stable_row_reg;
    assign m_settled       = settled_reg;
    assign m_pressed_count = pressed_reg;

endmodule

// ===== design/key_matrix_debouncer_core.sv =====
// channel | direction | signals
// --------+-----------+-------------------------------------------------------
// s_      | in        | s_valid s_ready s_row_index s_column_bits s_end_of_pass
// m_      | out       | m_valid m_ready m_stable_row m_settled m_pressed_count
// cfg_    | in        | cfg_valid cfg_ready cfg_data (debounce reload)
//
// an item runs idle, exec and form; ending the quiet period adds the sweep
// state, where the stable copy and the key recount walk one row a cycle
// one item is in flight at a time; input is taken only in the idle state
// a result waits in the output register while m_ready is low
// reset (aresetn low, synchronous) clears both row stores, the key total and
// sets the reload and quiet counter to five; cfg_ready is always high
module key_matrix_debouncer_core #(
    parameter int ROWS = kmd_pkg::ROWS_DEF,
    parameter int COLS = kmd_pkg::COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kmd_pkg::ROW_IDX_W-1:0]   s_row_index,
    input  logic [kmd_pkg::COL_BITS_W-1:0]  s_column_bits,
    input  logic                            s_end_of_pass,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kmd_pkg::COL_BITS_W-1:0]  m_stable_row,
    output logic                            m_settled,
    output logic [kmd_pkg::COUNT_W-1:0]     m_pressed_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kmd_pkg::RELOAD_W-1:0]    cfg_data
);

    kmd_pkg::kmd_cmd_t    cmd;
    kmd_pkg::kmd_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    kmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // row stores, counters and result register
    kmd_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_row_index     (s_row_index),
        .s_column_bits   (s_column_bits),
        .s_end_of_pass   (s_end_of_pass),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_stable_row    (m_stable_row),
        .m_settled       (m_settled),
        .m_pressed_count (m_pressed_count),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
